// ===== rtl/hsmc_pkg.sv =====
`timescale 1ns / 1ps

package hsmc_pkg;

    localparam int KEY_W        = 31;
    localparam int CNT_W        = 20;
    localparam int MODE_W       = 2;
    localparam int BUCKETS_DEF  = 1024;
    localparam int WAYS_DEF     = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

endpackage

// ===== rtl/hsmc_ram.sv =====
`timescale 1ns / 1ps

module hsmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hsmc_bucket_map.sv =====
`timescale 1ns / 1ps

// Bucket index = key mod BUCKETS. A power-of-two bucket count is a mask and
// answers in the start cycle; any other count is reduced one nibble a cycle.
module hsmc_bucket_map #(
    parameter int BUCKETS = hsmc_pkg::BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hsmc_pkg::KEY_W-1:0] i_key,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_idx
);

    import hsmc_pkg::*;

    localparam int  IDX_W = $clog2(BUCKETS);
    localparam bit  POW2  = (BUCKETS & (BUCKETS - 1)) == 0;

    generate
        if (POW2) begin : g_mask
            assign o_done = i_start;
            assign o_idx  = i_key[IDX_W-1:0];
        end else begin : g_reduce
            localparam int STEPS = (KEY_W + 3) / 4;
            localparam int SH_W  = STEPS * 4;
            localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
            localparam int RW    = IDX_W + 4;
            localparam logic [RW-1:0] B1 = RW'(BUCKETS);
            localparam logic [RW-1:0] B2 = RW'(BUCKETS * 2);
            localparam logic [RW-1:0] B4 = RW'(BUCKETS * 4);
            localparam logic [RW-1:0] B8 = RW'(BUCKETS * 8);

            logic            r_busy;
            logic            r_done;
            logic [CW-1:0]   r_cnt;
            logic [SH_W-1:0] r_sh;
            logic [IDX_W-1:0] r_rem;
            logic [RW-1:0]   x;
            logic [IDX_W-1:0] n_rem;

            // rem*16 + nibble < 16*BUCKETS, so four conditional subtracts suffice
            always_comb begin
                x = {r_rem, r_sh[SH_W-1 -: 4]};
                if (x >= B8) x = x - B8;
                if (x >= B4) x = x - B4;
                if (x >= B2) x = x - B2;
                if (x >= B1) x = x - B1;
                n_rem = x[IDX_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                        r_sh   <= SH_W'(i_key);
                        r_rem  <= '0;
                    end else if (r_busy) begin
                        r_rem <= n_rem;
                        r_sh  <= r_sh << 4;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CW'(STEPS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            assign o_done = r_done;
            assign o_idx  = r_rem;
        end
    endgenerate

endmodule

// ===== rtl/hash_set_match_counter_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Fields
// request   in         i_in_valid / o_in_stall    i_mode, i_key
// result    out        o_out_valid / i_out_stall  o_found, o_match_count, o_bucket_full
//
// One request at a time. Insert and query read the bucket row, then
// compare/update and write back, when BUCKETS is a power of two; other
// bucket counts first run the nibble-serial mod reduction.
// Clear walks every row of the bucket memory.
// After reset the same walk runs before the first request.
// A finished result sits in the output register; a stalled result holds the
// block only when the next result is ready to be loaded.
module hash_set_match_counter_core #(
    parameter int BUCKETS = hsmc_pkg::BUCKETS_DEF,
    parameter int WAYS    = hsmc_pkg::WAYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [hsmc_pkg::MODE_W-1:0] i_mode,
    input  logic [hsmc_pkg::KEY_W-1:0]  i_key,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [hsmc_pkg::CNT_W-1:0]  o_match_count,
    output logic                        o_bucket_full
);

    import hsmc_pkg::*;

    localparam int IDX_W  = $clog2(BUCKETS);
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int ROW_W  = FILL_W + WAYS * KEY_W;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HASH,
        S_RD,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_clr_addr;
    logic              r_clr_op;
    logic              r_ins;
    logic [KEY_W-1:0]  r_key;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_hit;
    logic              r_out_valid;
    logic              r_found;
    logic              r_full;
    logic [CNT_W-1:0]  r_count;

    logic              accept;
    logic              out_free;
    logic              map_start;
    logic              map_done;
    logic [IDX_W-1:0]  map_idx;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;
    logic [FILL_W-1:0] row_fill;
    logic              row_hit;
    logic              row_full;
    logic [ROW_W-1:0]  new_row;
    logic              q_hit;
    logic [CNT_W-1:0]  n_hit;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign map_start = accept && (i_mode == MODE_INSERT || i_mode == MODE_QUERY);

    hsmc_bucket_map #(
        .BUCKETS (BUCKETS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (map_start),
        .i_key   (i_key),
        .o_done  (map_done),
        .o_idx   (map_idx)
    );

    hsmc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (map_done),
        .i_raddr (map_idx),
        .o_rdata (ram_rdata)
    );

    // row layout: {fill, key[WAYS-1], ..., key[0]}
    always_comb begin
        row_fill = ram_rdata[ROW_W-1 -: FILL_W];
        row_full = row_fill >= FILL_W'(WAYS);
        row_hit  = 1'b0;
        new_row  = ram_rdata;
        for (int w = 0; w < WAYS; w++) begin
            if (FILL_W'(w) < row_fill && ram_rdata[w*KEY_W +: KEY_W] == r_key) begin
                row_hit = 1'b1;
            end
            if (FILL_W'(w) == row_fill) begin
                new_row[w*KEY_W +: KEY_W] = r_key;
            end
        end
        new_row[ROW_W-1 -: FILL_W] = row_fill + 1'b1;
        q_hit = !r_ins && row_hit;
        n_hit = (q_hit && r_hit != COUNT_MAX) ? r_hit + 1'b1 : r_hit;
    end

    assign ram_we    = (r_state == S_CLR) ||
                       (r_state == S_RD && out_free && r_ins && !row_full);
    assign ram_waddr = (r_state == S_CLR) ? r_clr_addr : r_idx;
    assign ram_wdata = (r_state == S_CLR) ? '0 : new_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_hit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (map_done) begin
                r_idx <= map_idx;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == IDX_W'(BUCKETS - 1)) begin
                        r_state <= r_clr_op ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_key <= i_key;
                        case (i_mode)
                            MODE_CLEAR: begin
                                r_hit      <= '0;
                                r_clr_op   <= 1'b1;
                                r_clr_addr <= '0;
                                r_state    <= S_CLR;
                            end
                            MODE_INSERT: begin
                                r_ins   <= 1'b1;
                                r_state <= map_done ? S_RD : S_HASH;
                            end
                            MODE_QUERY: begin
                                r_ins   <= 1'b0;
                                r_state <= map_done ? S_RD : S_HASH;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    if (map_done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_found     <= q_hit;
                        r_full      <= r_ins && row_full;
                        r_count     <= n_hit;
                        r_hit       <= n_hit;
                        r_state     <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_found     <= 1'b0;
                        r_full      <= 1'b0;
                        r_count     <= r_hit;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_count = r_count;
    assign o_bucket_full = r_full;

endmodule

// ===== rtl/hsmc_checker.sv =====
`timescale 1ns / 1ps

module hsmc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [hsmc_pkg::MODE_W-1:0] i_mode,
    input logic [hsmc_pkg::KEY_W-1:0]  i_key,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_found,
    input logic [hsmc_pkg::CNT_W-1:0]  o_match_count,
    input logic                        o_bucket_full
);

    // one request in flight: the block stalls right after taking one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while another is in flight");

    a_found_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> !o_bucket_full)
        else $error("found and bucket_full both set");

    a_found_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_match_count != '0))
        else $error("hit reported with zero match count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable({o_found, o_match_count, o_bucket_full})))
        else $error("stalled result changed");

endmodule

bind hash_set_match_counter_core hsmc_checker u_hsmc_checker (.*);
